// ----- rtl/core/wse_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and fixed field widths for the 2-D wave stencil engine.
// No dependencies; imported by every module of the block except wse_plane_ram.
package wse_pkg;

  // Fixed widths of the port fields
  localparam int OP_W        = 2;
  localparam int COORD_W     = 6;
  localparam int IN_W        = 32;
  localparam int KIND_W      = 2;
  localparam int GAIN_W      = 15;
  localparam int SIZE_W      = 7;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 15;

  // Register reset values and limits
  localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd4096;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
  localparam int MIN_SIZE   = 3;

  // Rounding of the Q16.32 product back to Q16.16
  localparam int FRAC_BITS  = 16;
  localparam int ROUND_HALF = 32768;

  // Three planes rotate through previous / current / next
  localparam int NUM_PLANES = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_COUPLING_GAIN = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_SIZE   = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_ACK  = 2'd0,
    KIND_STEP_DONE = 2'd1,
    KIND_READ_DATA = 2'd2
  } result_kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } ctrl_state_t;

  // Sweep sequencer phases; also tags the read data in the cycle after the read is issued
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PRIME,
    PH_A,
    PH_B
  } sweep_phase_t;

  typedef struct packed {
    sweep_phase_t phase;
    logic         first_col;
    logic         last;
  } sweep_tag_t;

  typedef struct packed {
    logic wr;
    logic sat;
    logic done;
  } stencil_stat_t;

  // Plane number that follows p in the rotation order
  function automatic logic [1:0] plane_after(input logic [1:0] p);
    logic [1:0] q;
    case (p)
      2'd0:    q = 2'd1;
      2'd1:    q = 2'd2;
      default: q = 2'd0;
    endcase
    return q;
  endfunction

endpackage

// ----- rtl/core/wave_2d_stencil_engine.sv -----
`timescale 1ns / 1ps
// Top level of the 2-D wave stencil engine: command port, plane RAMs and rotation.
// Depends on wse_pkg, wse_plane_ram, wse_sweep, wse_stencil.
//
// Load, read and no-op commands are taken in any cycle that busy is low and
// answer with a one-cycle result strobe in the next cycle, so they can run
// back to back. An advance holds busy high until its sweep of the active square,
// whose side is the active size clamped to MIN_SIZE..GRID_SIDE, ends, and its strobe
// comes in the first cycle with busy low. The sweep length is set by the
// current plane's RAM: each cell needs three fresh current-plane samples over
// two read ports, plus one priming read at the start of every row, and then the
// arithmetic pipeline drains. The receiver has no back-pressure: every result
// appears on result_valid for exactly one cycle and must be taken then.
module wave_2d_stencil_engine import wse_pkg::*; #(
  parameter int GRID_SIDE    = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [OP_W-1:0]        operation,
  input  logic [COORD_W-1:0]     row,
  input  logic [COORD_W-1:0]     col,
  input  logic                   plane_select,
  input  logic signed [IN_W-1:0] cell_value,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output logic                   result_valid,
  output logic [KIND_W-1:0]      result_kind,
  output logic signed [IN_W-1:0] read_value,
  output logic                   saturated
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int MAW   = $clog2(DEPTH);
  localparam int LDW   = (SW > IN_W) ? SW : IN_W;

  // configuration
  logic [GAIN_W-1:0] coupling_gain;
  logic [SIZE_W-1:0] active_size;

  // control
  ctrl_state_t  state, state_next;
  logic [1:0]   rotation, rotation_next;
  logic         sat_acc, sat_acc_next;
  logic         valid_next, rv_sel, rv_sel_next, saturated_next;
  result_kind_t kind, kind_next;
  logic         accept, in_grid, load_we, sweep_go;

  // plane roles
  logic [1:0] prv_idx, cur_idx, nxt_idx, ld_idx;

  // host access
  logic [MAW-1:0]         host_addr;
  logic signed [LDW-1:0]  ld_ext, ld_max, ld_min;
  logic [SW-1:0]          ld_val;

  // sweep and stencil
  logic [MAW-1:0]  sw_ra0, sw_ra1, sw_prv_ra, sw_tag_addr, st_wa, cur_ra0;
  sweep_tag_t      sw_tag;
  logic            sw_active;
  stencil_stat_t   st_stat;
  logic signed [SW-1:0] st_wd, cur_d0, cur_d1, prv_d;

  // RAM ports
  logic           ram_we  [NUM_PLANES];
  logic [MAW-1:0] ram_wa  [NUM_PLANES];
  logic [SW-1:0]  ram_wd  [NUM_PLANES];
  logic [MAW-1:0] ram_ra0 [NUM_PLANES];
  logic [MAW-1:0] ram_ra1 [NUM_PLANES];
  logic [SW-1:0]  ram_rd0 [NUM_PLANES];
  logic [SW-1:0]  ram_rd1 [NUM_PLANES];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coupling_gain <= GAIN_RESET;
      active_size   <= SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COUPLING_GAIN: coupling_gain <= cfg_wdata[GAIN_W-1:0];
        REG_ACTIVE_SIZE:   active_size   <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // host address, grid check and load saturation
  always_comb begin
    in_grid   = (int'(row) < GRID_SIDE) && (int'(col) < GRID_SIDE);
    host_addr = MAW'(row) * MAW'(GRID_SIDE) + MAW'(col);
    ld_ext    = LDW'(cell_value);
    ld_max    = LDW'(signed'({1'b0, {(SW-1){1'b1}}}));
    ld_min    = -ld_max - LDW'(1);
    if (ld_ext > ld_max) begin
      ld_val = SW'(ld_max);
    end else if (ld_ext < ld_min) begin
      ld_val = SW'(ld_min);
    end else begin
      ld_val = SW'(ld_ext);
    end
  end

  assign busy   = rst || (state != ST_IDLE);
  assign accept = start && !busy;

  // plane roles follow the rotation
  assign prv_idx = rotation;
  assign cur_idx = plane_after(rotation);
  assign nxt_idx = plane_after(cur_idx);
  assign ld_idx  = plane_select ? cur_idx : prv_idx;
  assign cur_ra0 = sw_active ? sw_ra0 : host_addr;

  // RAM port steering
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    always_comb begin
      ram_ra0[p] = (cur_idx == 2'(p)) ? cur_ra0 : sw_prv_ra;
      ram_ra1[p] = sw_ra1;
      ram_we[p]  = (st_stat.wr && (nxt_idx == 2'(p))) || (load_we && (ld_idx == 2'(p)));
      ram_wa[p]  = st_stat.wr ? st_wa : host_addr;
      ram_wd[p]  = st_stat.wr ? st_wd : ld_val;
    end

    wse_plane_ram #(
      .DEPTH (DEPTH),
      .AW    (MAW),
      .DW    (SW)
    ) u_ram (
      .clk    (clk),
      .we     (ram_we[p]),
      .waddr  (ram_wa[p]),
      .wdata  (ram_wd[p]),
      .raddr0 (ram_ra0[p]),
      .raddr1 (ram_ra1[p]),
      .rdata0 (ram_rd0[p]),
      .rdata1 (ram_rd1[p])
    );
  end

  assign cur_d0 = signed'(ram_rd0[cur_idx]);
  assign cur_d1 = signed'(ram_rd1[cur_idx]);
  assign prv_d  = signed'(ram_rd0[prv_idx]);

  wse_sweep #(
    .GRID_SIDE (GRID_SIDE),
    .MAW       (MAW)
  ) u_sweep (
    .clk      (clk),
    .rst      (rst),
    .go       (sweep_go),
    .size_cfg (active_size),
    .cur_ra0  (sw_ra0),
    .cur_ra1  (sw_ra1),
    .prv_ra   (sw_prv_ra),
    .tag      (sw_tag),
    .tag_addr (sw_tag_addr),
    .active   (sw_active)
  );

  wse_stencil #(
    .SW  (SW),
    .MAW (MAW)
  ) u_stencil (
    .clk      (clk),
    .rst      (rst),
    .tag      (sw_tag),
    .tag_addr (sw_tag_addr),
    .cur0     (cur_d0),
    .cur1     (cur_d1),
    .prv      (prv_d),
    .gain     (coupling_gain),
    .stat     (st_stat),
    .wr_addr  (st_wa),
    .wr_data  (st_wd)
  );

  // control registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rotation     <= 2'd0;
      sat_acc      <= 1'b0;
      result_valid <= 1'b0;
      rv_sel       <= 1'b0;
      kind         <= KIND_LOAD_ACK;
      saturated    <= 1'b0;
    end else begin
      state        <= state_next;
      rotation     <= rotation_next;
      sat_acc      <= sat_acc_next;
      result_valid <= valid_next;
      rv_sel       <= rv_sel_next;
      kind         <= kind_next;
      saturated    <= saturated_next;
    end
  end

  // command decode and step completion
  always_comb begin
    state_next     = state;
    rotation_next  = rotation;
    sat_acc_next   = sat_acc;
    valid_next     = 1'b0;
    rv_sel_next    = 1'b0;
    kind_next      = kind;
    saturated_next = saturated;
    load_we        = 1'b0;
    sweep_go       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          valid_next     = 1'b1;
          kind_next      = KIND_LOAD_ACK;
          saturated_next = 1'b0;
          case (op_t'(operation))
            OP_LOAD: load_we = in_grid;
            OP_READ: begin
              kind_next   = KIND_READ_DATA;
              rv_sel_next = in_grid;
            end
            OP_ADVANCE: begin
              valid_next   = 1'b0;
              sweep_go     = 1'b1;
              sat_acc_next = 1'b0;
              state_next   = ST_SWEEP;
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        sat_acc_next = sat_acc | st_stat.sat;
        if (st_stat.done) begin
          state_next     = ST_IDLE;
          valid_next     = 1'b1;
          kind_next      = KIND_STEP_DONE;
          saturated_next = sat_acc | st_stat.sat;
          rotation_next  = plane_after(rotation);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign result_kind = kind;
  assign read_value  = rv_sel ? IN_W'(cur_d0) : '0;

endmodule

// ----- rtl/core/wse_plane_ram.sv -----
`timescale 1ns / 1ps
// One sample plane: synchronous RAM, one write port, two registered read ports.
// Depends on nothing.
module wse_plane_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [DW-1:0] rdata0,
  output logic [DW-1:0] rdata1
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, registered
  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ----- rtl/core/wse_sweep.sv -----
`timescale 1ns / 1ps
// Sweep sequencer: walks the active square row by row and issues plane reads.
// Depends on wse_pkg.
module wse_sweep import wse_pkg::*; #(
  parameter int GRID_SIDE = 64,
  parameter int MAW       = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [SIZE_W-1:0] size_cfg,
  output logic [MAW-1:0]    cur_ra0,
  output logic [MAW-1:0]    cur_ra1,
  output logic [MAW-1:0]    prv_ra,
  output sweep_tag_t        tag,
  output logic [MAW-1:0]    tag_addr,
  output logic              active
);

  localparam int AW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int CW = $clog2(GRID_SIDE + 1);

  sweep_phase_t  ph, ph_next;
  logic [AW-1:0] i, i_next, j, j_next;
  logic [CW-1:0] n, n_next;
  logic          last_i, last_j;
  logic [AW-1:0] n_m2, up_i, dn_i, rt_j;

  function automatic logic [MAW-1:0] cell_addr(input logic [AW-1:0] r, input logic [AW-1:0] c);
    return MAW'(r) * MAW'(GRID_SIDE) + MAW'(c);
  endfunction

  // neighbour rows / columns with mirrored edges
  always_comb begin
    last_i = (CW'(i) == n - CW'(1));
    last_j = (CW'(j) == n - CW'(1));
    n_m2   = AW'(n - CW'(2));
    up_i   = (i == '0) ? AW'(1) : i - AW'(1);
    dn_i   = last_i ? n_m2 : i + AW'(1);
    rt_j   = last_j ? n_m2 : j + AW'(1);
  end

  // phase register and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= PH_IDLE;
      i  <= '0;
      j  <= '0;
      n  <= CW'(MIN_SIZE);
    end else begin
      ph <= ph_next;
      i  <= i_next;
      j  <= j_next;
      n  <= n_next;
    end
  end

  // next phase, read addresses and data tag
  always_comb begin
    ph_next  = ph;
    i_next   = i;
    j_next   = j;
    n_next   = n;
    cur_ra0  = cell_addr(i, j);
    cur_ra1  = cell_addr(dn_i, j);
    prv_ra   = cell_addr(i, j);
    tag_addr = cell_addr(i, j);
    tag      = '{phase: PH_IDLE, first_col: 1'b0, last: 1'b0};
    active   = (ph != PH_IDLE);
    case (ph)
      PH_IDLE: begin
        if (go) begin
          ph_next = PH_PRIME;
          i_next  = '0;
          j_next  = '0;
          if (int'(size_cfg) < MIN_SIZE) begin
            n_next = CW'(MIN_SIZE);
          end else if (int'(size_cfg) > GRID_SIDE) begin
            n_next = CW'(GRID_SIDE);
          end else begin
            n_next = CW'(size_cfg);
          end
        end
      end
      PH_PRIME: begin
        // centre of the first column of the row
        cur_ra0   = cell_addr(i, '0);
        tag.phase = PH_PRIME;
        ph_next   = PH_A;
      end
      PH_A: begin
        // cells above and below, and the previous-plane cell
        cur_ra0   = cell_addr(up_i, j);
        cur_ra1   = cell_addr(dn_i, j);
        tag.phase = PH_A;
        ph_next   = PH_B;
      end
      PH_B: begin
        // right-hand cell; slides into the centre afterwards
        cur_ra0       = cell_addr(i, rt_j);
        tag.phase     = PH_B;
        tag.first_col = (j == '0);
        tag.last      = last_i && last_j;
        if (last_j) begin
          j_next = '0;
          if (last_i) begin
            ph_next = PH_IDLE;
          end else begin
            i_next  = i + AW'(1);
            ph_next = PH_PRIME;
          end
        end else begin
          j_next  = j + AW'(1);
          ph_next = PH_A;
        end
      end
      default: ph_next = PH_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/wse_stencil.sv -----
`timescale 1ns / 1ps
// Stencil datapath: gathers neighbours, forms the Laplacian, scales, rounds,
// adds 2*cur - prev, saturates. Depends on wse_pkg.
module wse_stencil import wse_pkg::*; #(
  parameter int SW  = 32,
  parameter int MAW = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sweep_tag_t           tag,
  input  logic [MAW-1:0]       tag_addr,
  input  logic signed [SW-1:0] cur0,
  input  logic signed [SW-1:0] cur1,
  input  logic signed [SW-1:0] prv,
  input  logic [GAIN_W-1:0]    gain,
  output stencil_stat_t        stat,
  output logic [MAW-1:0]       wr_addr,
  output logic signed [SW-1:0] wr_data
);

  localparam int LW   = SW + 3;
  localparam int BW   = SW + 2;
  localparam int PW   = LW + GAIN_W + 1;
  localparam int SUMW = SW + 4;

  sweep_tag_t            tag_d;
  logic [MAW-1:0]        addr_d;
  logic signed [SW-1:0]  l_r, c_r, up_r, dn_r, pv_r;
  logic signed [SW-1:0]  left;
  logic signed [LW-1:0]  lap_c, lap_r;
  logic signed [BW-1:0]  base_c, base_r, base2_r;
  logic                  s1_vld, s1_last, s2_vld, s2_last;
  logic [MAW-1:0]        s1_addr, s2_addr;
  logic signed [PW-1:0]  prod_r, prod_rnd, term_w;
  logic signed [LW-1:0]  term;
  logic signed [SUMW-1:0] sum, smax, smin;
  logic                  over, under;

  // tag and stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_d   <= '{phase: PH_IDLE, first_col: 1'b0, last: 1'b0};
      s1_vld  <= 1'b0;
      s1_last <= 1'b0;
      s2_vld  <= 1'b0;
      s2_last <= 1'b0;
    end else begin
      tag_d   <= tag;
      s1_vld  <= (tag_d.phase == PH_B);
      s1_last <= tag_d.last;
      s2_vld  <= s1_vld;
      s2_last <= s1_last;
    end
  end

  // Laplacian and 2*cur - prev once the right-hand cell arrives
  always_comb begin
    left   = tag_d.first_col ? cur0 : l_r;
    lap_c  = LW'(up_r) + LW'(dn_r) + LW'(left) + LW'(cur0) - (LW'(c_r) <<< 2);
    base_c = (BW'(c_r) <<< 1) - BW'(pv_r);
  end

  // capture read data, slide the row window, stage 1 and stage 2
  always_ff @(posedge clk) begin
    addr_d <= tag_addr;
    case (tag_d.phase)
      PH_PRIME: c_r <= cur0;
      PH_A: begin
        up_r <= cur0;
        dn_r <= cur1;
        pv_r <= prv;
      end
      PH_B: begin
        l_r     <= c_r;
        c_r     <= cur0;
        lap_r   <= lap_c;
        base_r  <= base_c;
        s1_addr <= addr_d;
      end
      default: ;
    endcase
    prod_r  <= PW'(lap_r) * PW'(signed'({1'b0, gain}));
    base2_r <= base_r;
    s2_addr <= s1_addr;
  end

  // round half up, add, saturate
  always_comb begin
    prod_rnd = prod_r + PW'(ROUND_HALF);
    term_w   = prod_rnd >>> FRAC_BITS;
    term     = LW'(term_w);
    sum      = SUMW'(base2_r) + SUMW'(term);
    smax     = SUMW'(signed'({1'b0, {(SW-1){1'b1}}}));
    smin     = -smax - SUMW'(1);
    over     = (sum > smax);
    under    = (sum < smin);
    if (over) begin
      wr_data = SW'(smax);
    end else if (under) begin
      wr_data = SW'(smin);
    end else begin
      wr_data = SW'(sum);
    end
    wr_addr   = s2_addr;
    stat.wr   = s2_vld;
    stat.sat  = s2_vld && (over || under);
    stat.done = s2_vld && s2_last;
  end

endmodule

// ----- rtl/core/wse_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the 2-D wave stencil engine, bound to the top level.
// Depends on wse_pkg and wave_2d_stencil_engine.
module wse_checker import wse_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic [OP_W-1:0]        operation,
  input logic                   result_valid,
  input logic [KIND_W-1:0]      result_kind,
  input logic signed [IN_W-1:0] read_value,
  input logic                   saturated
);

  // load, read and no-op commands answer in the next cycle
  a_quick_reply: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (operation != OP_ADVANCE) |=> result_valid)
    else $error("load/read/no-op transfer not answered in the next cycle");

  // an advance raises busy and gives no immediate result
  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (operation == OP_ADVANCE) |=> busy && !result_valid)
    else $error("advance transfer did not hold busy");

  // step result comes just as busy drops
  a_step_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind == KIND_STEP_DONE) |-> $past(busy) && !busy)
    else $error("step result without end of sweep");

  // only steps flag saturation, only reads carry data
  a_side_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind != KIND_STEP_DONE) |-> !saturated)
    else $error("saturation flagged on a non-step result");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind != KIND_READ_DATA) |-> (read_value == '0))
    else $error("read_value not zero on a non-read result");

endmodule

bind wave_2d_stencil_engine wse_checker u_wse_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .operation    (operation),
  .result_valid (result_valid),
  .result_kind  (result_kind),
  .read_value   (read_value),
  .saturated    (saturated)
);
